@@ rtl/mrr_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU response receiver package
// Shared widths, operation, status and register codes, and the CRC step.
// ----------------------------------------------------------------------------
`default_nettype none

package mrr_pkg;

  localparam int MAX_FRAME = 16;
  localparam int IDX_W     = $clog2(MAX_FRAME + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_CRC     = 3'd2,
    ST_HEADER  = 3'd3,
    ST_SHORT   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_GAP     = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_FUNC    = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mrr_if.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU response receiver channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;
  logic [7:0] slave_address;

  modport source (output valid, output operation, output rx_byte, output slave_address,
                  input ready);
  modport sink   (input valid, input operation, input rx_byte, input slave_address,
                  output ready);
endinterface

interface mrr_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] reading;
  logic [4:0]  frame_bytes;

  modport source (output valid, output status, output reading, output frame_bytes,
                  input ready);
  modport sink   (input valid, input status, input reading, input frame_bytes,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/modbus_rtu_response_receiver.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU response receiver
// Frames received bytes on gap, full buffer or timeout, checks CRC-16 and
// header, and packs the data bytes into a 32-bit reading.
// ----------------------------------------------------------------------------
// Latency: a result is valid in the cycle after the transaction that ends it.
// Throughput: one input transaction per cycle; the result register stalls
//   input only while a result waits and is not taken.
// Reset: synchronous, active high; clears control state and loads register
//   defaults (gap 305, timeout 500000, function code 3). No clearing pass.
`default_nettype none

module modbus_rtu_response_receiver
  import mrr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  mrr_item_if.sink         item,
  mrr_result_if.source     result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration registers
  logic [15:0] gap_ticks;
  logic [23:0] timeout_ticks;
  logic [7:0]  function_code;

  // frame state
  logic             busy;
  logic [7:0]       expected_address;
  logic [IDX_W-1:0] byte_index;
  logic [15:0]      running_crc;
  logic [15:0]      last_two_bytes;
  logic             header_bad;
  logic [7:0]       data_count;
  logic [31:0]      packed_value;
  logic [15:0]      gap_counter;
  logic [23:0]      timeout_counter;

  logic             busy_next;
  logic [7:0]       expected_address_next;
  logic [IDX_W-1:0] byte_index_next;
  logic [15:0]      running_crc_next;
  logic [15:0]      last_two_bytes_next;
  logic             header_bad_next;
  logic [7:0]       data_count_next;
  logic [31:0]      packed_value_next;
  logic [15:0]      gap_counter_next;
  logic [23:0]      timeout_counter_next;

  // result register
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_reading;
  logic [4:0]  out_frame_bytes;

  logic        accept;
  logic        emit;
  status_t     emit_status;
  logic [31:0] emit_reading;
  logic [4:0]  emit_frame_bytes;

  reg_idx_t cfg_idx;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    case (cfg_idx)
      REG_GAP:     prdata = {16'h0000, gap_ticks};
      REG_TIMEOUT: prdata = {8'h00, timeout_ticks};
      REG_FUNC:    prdata = {24'h000000, function_code};
      default:     prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks     <= 16'd305;
      timeout_ticks <= 24'd500000;
      function_code <= 8'h03;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_GAP:     gap_ticks     <= pwdata[15:0];
        REG_TIMEOUT: timeout_ticks <= pwdata[23:0];
        REG_FUNC:    function_code <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  assign item.ready   = ~out_valid | result.ready;
  assign accept       = item.valid & item.ready;

  // item processing
  always_comb begin
    op_t              op;
    logic [IDX_W-1:0] b_idx;
    logic [15:0]      b_crc;
    logic [15:0]      b_last;
    logic             b_hdr;
    logic [7:0]       b_dc;
    logic [31:0]      b_pack;
    logic [IDX_W-1:0] f_idx;
    logic [15:0]      f_crc;
    logic [15:0]      f_last;
    logic             f_hdr;
    logic [7:0]       f_dc;
    logic [31:0]      f_pack;
    logic [7:0]       k8;
    logic [7:0]       got;
    logic [7:0]       taken;
    logic [7:0]       rest;
    logic [31:0]      value;
    status_t          fin_status;
    logic [31:0]      fin_reading;
    logic [24:0]      to_inc;

    op = op_t'(item.operation);
    k8 = 8'(byte_index);

    // state after taking a byte
    b_idx  = byte_index + IDX_W'(1);
    b_crc  = (byte_index >= IDX_W'(2)) ? crc_feed(running_crc, last_two_bytes[15:8])
                                      : running_crc;
    b_last = {last_two_bytes[7:0], item.rx_byte};
    b_hdr  = header_bad;
    if (byte_index == IDX_W'(0) && item.rx_byte != expected_address) begin
      b_hdr = 1'b1;
    end
    if (byte_index == IDX_W'(1) && item.rx_byte != function_code) begin
      b_hdr = 1'b1;
    end
    b_dc = (byte_index == IDX_W'(2)) ? item.rx_byte : data_count;
    b_pack = packed_value;
    if (k8 >= 8'd3 && (k8 - 8'd3) < data_count) begin
      b_pack = {packed_value[23:0], item.rx_byte};
    end

    // frame end checks
    if (op == OP_BYTE) begin
      f_idx = b_idx; f_crc = b_crc; f_last = b_last;
      f_hdr = b_hdr; f_dc = b_dc; f_pack = b_pack;
    end else begin
      f_idx = byte_index; f_crc = running_crc; f_last = last_two_bytes;
      f_hdr = header_bad; f_dc = data_count; f_pack = packed_value;
    end
    got   = 8'(f_idx) - 8'd3;
    taken = (f_dc < got) ? f_dc : got;
    rest  = f_dc - taken;
    value = f_pack;
    if (rest >= 8'd4) begin
      value = 32'h0000_0000;
    end else begin
      value = f_pack << {rest[1:0], 3'b000};
    end
    if (f_idx < IDX_W'(5)) begin
      fin_status = ST_SHORT;  fin_reading = 32'h0000_0000;
    end else if (f_crc != {f_last[7:0], f_last[15:8]}) begin
      fin_status = ST_CRC;    fin_reading = 32'h0000_0000;
    end else if (f_hdr) begin
      fin_status = ST_HEADER; fin_reading = 32'h0000_0000;
    end else begin
      fin_status = ST_OK;     fin_reading = value;
    end

    to_inc = {1'b0, timeout_counter} + 25'd1;

    busy_next             = busy;
    expected_address_next = expected_address;
    byte_index_next       = byte_index;
    running_crc_next      = running_crc;
    last_two_bytes_next   = last_two_bytes;
    header_bad_next       = header_bad;
    data_count_next       = data_count;
    packed_value_next     = packed_value;
    gap_counter_next      = gap_counter;
    timeout_counter_next  = timeout_counter;
    emit                  = 1'b0;
    emit_status           = fin_status;
    emit_reading          = fin_reading;
    emit_frame_bytes      = 5'(f_idx);

    if (accept) begin
      case (op)
        OP_START: begin
          busy_next             = 1'b1;
          expected_address_next = item.slave_address;
          byte_index_next       = '0;
          running_crc_next      = CRC_INIT;
          last_two_bytes_next   = 16'h0000;
          header_bad_next       = 1'b0;
          data_count_next       = 8'h00;
          packed_value_next     = 32'h0000_0000;
          gap_counter_next      = 16'h0000;
          timeout_counter_next  = 24'h000000;
        end
        OP_BYTE: begin
          if (busy) begin
            byte_index_next     = b_idx;
            running_crc_next    = b_crc;
            last_two_bytes_next = b_last;
            header_bad_next     = b_hdr;
            data_count_next     = b_dc;
            packed_value_next   = b_pack;
            gap_counter_next    = 16'h0000;
            if (32'(b_idx) >= MAX_FRAME) begin
              emit      = 1'b1;
              busy_next = 1'b0;
            end
          end
        end
        OP_TICK: begin
          if (busy) begin
            if (byte_index != '0 && gap_counter >= gap_ticks) begin
              emit      = 1'b1;
              busy_next = 1'b0;
            end else begin
              if (byte_index != '0) begin
                gap_counter_next = gap_counter + 16'd1;
              end
              if (to_inc >= {1'b0, timeout_ticks}) begin
                emit         = 1'b1;
                busy_next    = 1'b0;
                emit_status  = ST_TIMEOUT;
                emit_reading = 32'h0000_0000;
              end else begin
                timeout_counter_next = to_inc[23:0];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      expected_address <= 8'h00;
      byte_index       <= '0;
      running_crc      <= CRC_INIT;
      last_two_bytes   <= 16'h0000;
      header_bad       <= 1'b0;
      data_count       <= 8'h00;
      packed_value     <= 32'h0000_0000;
      gap_counter      <= 16'h0000;
      timeout_counter  <= 24'h000000;
    end else begin
      busy             <= busy_next;
      expected_address <= expected_address_next;
      byte_index       <= byte_index_next;
      running_crc      <= running_crc_next;
      last_two_bytes   <= last_two_bytes_next;
      header_bad       <= header_bad_next;
      data_count       <= data_count_next;
      packed_value     <= packed_value_next;
      gap_counter      <= gap_counter_next;
      timeout_counter  <= timeout_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status      <= emit_status;
      out_reading     <= emit_reading;
      out_frame_bytes <= emit_frame_bytes;
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.reading     = out_reading;
  assign result.frame_bytes = out_frame_bytes;

endmodule

`default_nettype wire
